/* hdl/arpm_pkg.sv */
// Shared types, widths and constants of the audio RMS / peak level meter.
// No dependencies; the accumulator, divide/root, log2 and top-level files import this package.
package arpm_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int WORD_W          = 32;
   localparam int OUT_W           = 16;
   localparam int SUM_W           = 64;
   localparam int TALLY_W         = 32;
   localparam int ROOT_W          = 32;
   // log2 in Q16: 6-bit integer part, 16 fraction bits
   localparam int LOG_W           = 22;
   localparam int FRAC_W          = 16;
   // dB difference in log2 Q16 and its product with the dB scale
   localparam int D_W             = 25;
   localparam int K_W             = 27;
   localparam int P_W             = D_W + K_W;
   localparam int R_W             = P_W - 32;
   // round(2^16 * 256 * 10*log10(2))
   localparam logic [K_W-1:0] DB_K = K_W'(50504453);

   // Accumulator control from the sequencer
   typedef struct packed {
      logic capture;
      logic square;
      logic update;
      logic clear;
   } acc_ctl_type;

   // Same log2 as the hardware unit, evaluated at elaboration for full scale
   function automatic logic [LOG_W-1:0] log2_q16_const(input logic [63:0] x);
      logic [5:0]  n;
      logic [63:0] xs;
      logic [31:0] m;
      logic [63:0] pr;
      logic [15:0] frac;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) n = 6'(i);
      end
      xs   = x << (6'd63 - n);
      m    = xs[63:32];
      frac = '0;
      for (int i = 15; i >= 0; i--) begin
         pr = 64'(m) * 64'(m);
         if (pr[63]) begin
            m       = pr[63:32];
            frac[i] = 1'b1;
         end else begin
            m = pr[62:31];
         end
      end
      return {n, frac};
   endfunction

endpackage

/* hdl/arpm_if.sv */
// Valid/ready channel interfaces for requests and level results.
// Depends on nothing; used by the top level and the checker.
interface arpm_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_word;
   logic               sample_present;
   logic               last;

   modport source (output valid, sample_word, sample_present, last, input ready);
   modport sink   (input valid, sample_word, sample_present, last, output ready);
   modport mon    (input valid, ready, sample_word, sample_present, last);
endinterface

interface arpm_rsp_if;
   logic               valid;
   logic               ready;
   logic        [15:0] rms_level;
   logic signed [15:0] rms_db;
   logic               rms_silent;
   logic signed [15:0] peak_db;
   logic               peak_silent;
   logic signed [15:0] peak_value;
   logic signed [15:0] min_value;
   logic signed [15:0] max_value;
   logic        [31:0] sample_total;
   logic               window_empty;

   modport source (output valid, rms_level, rms_db, rms_silent, peak_db, peak_silent,
                   peak_value, min_value, max_value, sample_total, window_empty,
                   input ready);
   modport sink   (input valid, rms_level, rms_db, rms_silent, peak_db, peak_silent,
                   peak_value, min_value, max_value, sample_total, window_empty,
                   output ready);
   modport mon    (input valid, ready, rms_level, rms_db, rms_silent, peak_db,
                   peak_silent, peak_value, min_value, max_value, sample_total,
                   window_empty);
endinterface

/* hdl/arpm_accum.sv */
// Window accumulators: sum of squares, sample count, min, max and peak.
// Depends on arpm_pkg for widths and the control struct.
module arpm_accum
   import arpm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  acc_ctl_type                   ctl,
   input  logic        [WORD_W-1:0]      word,
   output logic        [SUM_W-1:0]       sum,
   output logic        [TALLY_W-1:0]     tally,
   output logic signed [SAMPLE_BITS-1:0] run_min,
   output logic signed [SAMPLE_BITS-1:0] run_max,
   output logic signed [SAMPLE_BITS-1:0] peak,
   output logic        [SAMPLE_BITS-2:0] peak_mag
);

   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_FS  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam int SQ_W = 2 * SAMPLE_BITS;

   // magnitude, with the most negative code held at full scale
   function automatic logic [SAMPLE_BITS-2:0] mag(input logic signed [SAMPLE_BITS-1:0] v);
      logic signed [SAMPLE_BITS-1:0] neg;
      neg = -v;
      if (v == S_MIN) return S_FS[SAMPLE_BITS-2:0];
      else if (v[SAMPLE_BITS-1]) return neg[SAMPLE_BITS-2:0];
      else return v[SAMPLE_BITS-2:0];
   endfunction

   logic signed [SAMPLE_BITS-1:0] s_ff;
   logic        [SQ_W-1:0]        sq_ff;
   logic        [SUM_W-1:0]       sum_ff;
   logic        [TALLY_W-1:0]     tally_ff;
   logic signed [SAMPLE_BITS-1:0] min_ff;
   logic signed [SAMPLE_BITS-1:0] max_ff;
   logic signed [SAMPLE_BITS-1:0] peak_ff;
   logic signed [SQ_W-1:0]        prod;
   logic        [SUM_W:0]         sum_add;
   logic                          room;

   assign prod    = s_ff * s_ff;
   assign sum_add = {1'b0, sum_ff} + (SUM_W+1)'(sq_ff);
   assign room    = (tally_ff != '1) && !sum_add[SUM_W];

   // sample and square staging
   always_ff @(posedge clock) begin
      if (ctl.capture) s_ff  <= word[WORD_W-1 -: SAMPLE_BITS];
      if (ctl.square)  sq_ff <= prod;
   end

   // running statistics
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         sum_ff   <= '0;
         tally_ff <= '0;
         min_ff   <= S_FS;
         max_ff   <= S_MIN;
         peak_ff  <= '0;
      end else if (ctl.update) begin
         if (room) begin
            sum_ff   <= sum_add[SUM_W-1:0];
            tally_ff <= tally_ff + 1'b1;
         end
         if (s_ff < min_ff) min_ff <= s_ff;
         if (s_ff > max_ff) max_ff <= s_ff;
         if (mag(s_ff) > mag(peak_ff)) peak_ff <= s_ff;
      end
   end

   assign sum      = sum_ff;
   assign tally    = tally_ff;
   assign run_min  = min_ff;
   assign run_max  = max_ff;
   assign peak     = peak_ff;
   assign peak_mag = mag(peak_ff);

endmodule

/* hdl/arpm_divsqrt.sv */
// Bit-serial mean and root: restoring divide, then digit-by-digit square root.
// Depends on arpm_pkg for widths.
module arpm_divsqrt
   import arpm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   dividend,
   input  logic [TALLY_W-1:0] divisor,
   output logic               done,
   output logic [ROOT_W-1:0]  root
);

   typedef enum logic [1:0] {IDLE, DIV, SQRT} state_type;

   state_type          state_ff, state_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [SUM_W-1:0]   q_ff, q_in;
   logic [TALLY_W-1:0] rem_ff, rem_in;
   logic [ROOT_W+1:0]  rm_ff, rm_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic               done_ff, done_in;
   logic [TALLY_W:0]   rem_sh;
   logic [ROOT_W+3:0]  rm_sh;
   logic [ROOT_W+3:0]  trial;

   assign rem_sh = {rem_ff, q_ff[SUM_W-1]};
   assign rm_sh  = {rm_ff, q_ff[SUM_W-1:SUM_W-2]};
   assign trial  = (ROOT_W+4)'({root_ff, 2'b01});

   // one quotient bit or one root bit per cycle
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      rm_in    = rm_ff;
      root_in  = root_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               q_in     = dividend;
               rem_in   = '0;
               cnt_in   = 6'd63;
               state_in = DIV;
            end
         end
         DIV: begin
            if (rem_sh >= {1'b0, divisor}) begin
               rem_in = TALLY_W'(rem_sh - {1'b0, divisor});
               q_in   = {q_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[TALLY_W-1:0];
               q_in   = {q_ff[SUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = 6'(ROOT_W - 1);
               rm_in    = '0;
               root_in  = '0;
               state_in = SQRT;
            end
         end
         SQRT: begin
            if (rm_sh >= trial) begin
               rm_in   = (ROOT_W+2)'(rm_sh - trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rm_in   = rm_sh[ROOT_W+1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            q_in   = {q_ff[SUM_W-3:0], 2'b00};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      rm_ff   <= rm_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* hdl/arpm_log2.sv */
// Shared log2 unit in Q16: shift normalization, then one squaring per fraction bit.
// Depends on arpm_pkg for widths; the operand must be nonzero.
module arpm_log2
   import arpm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [63:0]      x,
   output logic             done,
   output logic [LOG_W-1:0] result
);

   typedef enum logic [1:0] {IDLE, NORM, SQR} state_type;

   state_type          state_ff, state_in;
   logic [63:0]        x_ff, x_in;
   logic [5:0]         n_ff, n_in;
   logic [31:0]        m_ff, m_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [63:0]        pr;

   assign pr = 64'(m_ff) * 64'(m_ff);

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      n_in     = n_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               x_in     = x;
               n_in     = 6'd63;
               frac_in  = '0;
               state_in = NORM;
            end
         end
         // move the top set bit to bit 63, a byte at a time where possible
         NORM: begin
            if (x_ff[63]) begin
               m_in     = x_ff[63:32];
               cnt_in   = 4'(FRAC_W - 1);
               state_in = SQR;
            end else if (x_ff[63:56] == '0) begin
               x_in = {x_ff[55:0], 8'h00};
               n_in = n_ff - 6'd8;
            end else begin
               x_in = {x_ff[62:0], 1'b0};
               n_in = n_ff - 6'd1;
            end
         end
         // square the Q31 mantissa; overflow past 2 yields a one bit
         SQR: begin
            if (pr[63]) begin
               m_in            = pr[63:32];
               frac_in[cnt_ff] = 1'b1;
            end else begin
               m_in = pr[62:31];
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff    <= x_in;
      n_ff    <= n_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
   end

   assign done   = done_ff;
   assign result = {n_ff, frac_ff};

endmodule

/* hdl/audio_rms_peak_level_meter.sv */
// Sample item: capture, square and accumulate steps; one item in flight at a time.
// Window close: a close step, the divide and root, up to three log2 runs (start,
// normalize steps, one squaring per fraction bit, done), up to two dB steps (multiply
// and round), a peak check and delivery.
// The result waits in an output register, so the next window starts while it is held.
// Synchronous active-high reset clears the sequencer, accumulators and result valid.
module audio_rms_peak_level_meter
   import arpm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   arpm_req_if.sink   req_ch,
   arpm_rsp_if.source rsp_ch
);

   localparam logic [63:0]      FS  = 64'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic [LOG_W-1:0] LFS = log2_q16_const(FS);

   typedef enum logic [3:0] {
      IDLE, SQUARE, ADD, CLOSE, DS_WAIT, LS_GO, LS_WAIT, LT_GO, LT_WAIT,
      PK_CHECK, LP_GO, LP_WAIT, DB_MUL, DB_RND, DELIVER
   } state_type;

   state_type                     state_ff, state_in;
   logic                          last_ff, last_in;
   logic        [OUT_W-1:0]       lvl_ff, lvl_in;
   logic signed [OUT_W-1:0]       rdb_ff, rdb_in;
   logic                          rsil_ff, rsil_in;
   logic signed [OUT_W-1:0]       pdb_ff, pdb_in;
   logic                          psil_ff, psil_in;
   logic                          empty_ff, empty_in;
   logic        [LOG_W-1:0]       lsum_ff, lsum_in;
   logic signed [D_W-1:0]         d_ff, d_in;
   logic signed [P_W-1:0]         p_ff, p_in;
   logic                          dbpk_ff, dbpk_in;
   logic                          ov_ff, ov_in;
   logic        [OUT_W-1:0]       o_lvl_ff, o_lvl_in;
   logic signed [OUT_W-1:0]       o_rdb_ff, o_rdb_in;
   logic                          o_rsil_ff, o_rsil_in;
   logic signed [OUT_W-1:0]       o_pdb_ff, o_pdb_in;
   logic                          o_psil_ff, o_psil_in;
   logic signed [OUT_W-1:0]       o_pk_ff, o_pk_in;
   logic signed [OUT_W-1:0]       o_min_ff, o_min_in;
   logic signed [OUT_W-1:0]       o_max_ff, o_max_in;
   logic        [TALLY_W-1:0]     o_tot_ff, o_tot_in;
   logic                          o_emp_ff, o_emp_in;

   acc_ctl_type                   acc_ctl;
   logic        [SUM_W-1:0]       sum;
   logic        [TALLY_W-1:0]     tally;
   logic signed [SAMPLE_BITS-1:0] run_min, run_max, peak;
   logic        [SAMPLE_BITS-2:0] peak_mag;
   logic                          ds_start, ds_done;
   logic        [ROOT_W-1:0]      root;
   logic                          log_start, log_done;
   logic        [63:0]            log_x;
   logic        [LOG_W-1:0]       log_res;
   logic signed [R_W-1:0]         rnd;
   logic signed [OUT_W-1:0]       db_sat;
   logic signed [31:0]            min_ext, max_ext, pk_ext;

   arpm_accum #(.SAMPLE_BITS(SAMPLE_BITS)) u_accum (
      .clock    (clock),
      .reset    (reset),
      .ctl      (acc_ctl),
      .word     (req_ch.sample_word),
      .sum      (sum),
      .tally    (tally),
      .run_min  (run_min),
      .run_max  (run_max),
      .peak     (peak),
      .peak_mag (peak_mag)
   );

   arpm_divsqrt u_divsqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (ds_start),
      .dividend (sum),
      .divisor  (tally),
      .done     (ds_done),
      .root     (root)
   );

   arpm_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   // dB rounding: floor((p + 2^31) / 2^32), then saturate to 16 bits
   assign rnd = R_W'((p_ff + P_W'(64'sd2147483648)) >>> 32);
   always_comb begin
      if (rnd > R_W'(32767))       db_sat = 16'sh7fff;
      else if (rnd < -R_W'(32768)) db_sat = 16'sh8000;
      else                         db_sat = rnd[OUT_W-1:0];
   end

   // sample fields sign-extend or truncate to the 16-bit outputs
   assign min_ext = 32'(run_min);
   assign max_ext = 32'(run_max);
   assign pk_ext  = 32'(peak);

   // log2 operand by sequencer step
   assign log_start = (state_ff == LS_GO) || (state_ff == LT_GO) || (state_ff == LP_GO);
   always_comb begin
      unique case (state_ff)
         LS_GO:   log_x = sum;
         LT_GO:   log_x = 64'(tally);
         default: log_x = 64'(peak_mag);
      endcase
   end

   assign ds_start      = (state_ff == CLOSE) && (tally != '0);
   assign req_ch.ready  = (state_ff == IDLE);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      last_in    = last_ff;
      lvl_in     = lvl_ff;
      rdb_in     = rdb_ff;
      rsil_in    = rsil_ff;
      pdb_in     = pdb_ff;
      psil_in    = psil_ff;
      empty_in   = empty_ff;
      lsum_in    = lsum_ff;
      d_in       = d_ff;
      p_in       = p_ff;
      dbpk_in    = dbpk_ff;
      ov_in      = ov_ff;
      o_lvl_in   = o_lvl_ff;
      o_rdb_in   = o_rdb_ff;
      o_rsil_in  = o_rsil_ff;
      o_pdb_in   = o_pdb_ff;
      o_psil_in  = o_psil_ff;
      o_pk_in    = o_pk_ff;
      o_min_in   = o_min_ff;
      o_max_in   = o_max_ff;
      o_tot_in   = o_tot_ff;
      o_emp_in   = o_emp_ff;
      acc_ctl    = '0;

      // result leaves on its transfer
      if (ov_ff && rsp_ch.ready) ov_in = 1'b0;

      unique case (state_ff)
         IDLE: begin
            if (req_ch.valid) begin
               last_in         = req_ch.last;
               acc_ctl.capture = req_ch.sample_present;
               if (req_ch.sample_present) state_in = SQUARE;
               else if (req_ch.last)      state_in = CLOSE;
            end
         end
         SQUARE: begin
            acc_ctl.square = 1'b1;
            state_in       = ADD;
         end
         ADD: begin
            acc_ctl.update = 1'b1;
            state_in       = last_ff ? CLOSE : IDLE;
         end
         CLOSE: begin
            lvl_in  = '0;
            rdb_in  = '0;
            pdb_in  = '0;
            rsil_in = 1'b0;
            psil_in = 1'b0;
            if (tally == '0) begin
               empty_in = 1'b1;
               rsil_in  = 1'b1;
               psil_in  = 1'b1;
               state_in = DELIVER;
            end else begin
               empty_in = 1'b0;
               state_in = DS_WAIT;
            end
         end
         DS_WAIT: begin
            if (ds_done) begin
               lvl_in = root[OUT_W-1:0];
               if (sum == '0) begin
                  rsil_in  = 1'b1;
                  state_in = PK_CHECK;
               end else begin
                  state_in = LS_GO;
               end
            end
         end
         LS_GO:   state_in = LS_WAIT;
         LS_WAIT: begin
            if (log_done) begin
               lsum_in  = log_res;
               state_in = LT_GO;
            end
         end
         LT_GO:   state_in = LT_WAIT;
         LT_WAIT: begin
            if (log_done) begin
               d_in     = signed'(D_W'(lsum_ff)) - signed'(D_W'(log_res))
                          - signed'(D_W'({LFS, 1'b0}));
               dbpk_in  = 1'b0;
               state_in = DB_MUL;
            end
         end
         DB_MUL: begin
            p_in     = P_W'(d_ff) * P_W'(signed'({1'b0, DB_K[K_W-2:0]}));
            state_in = DB_RND;
         end
         DB_RND: begin
            if (dbpk_ff) begin
               pdb_in   = db_sat;
               state_in = DELIVER;
            end else begin
               rdb_in   = db_sat;
               state_in = PK_CHECK;
            end
         end
         PK_CHECK: begin
            if (peak_mag == '0) begin
               psil_in  = 1'b1;
               state_in = DELIVER;
            end else begin
               state_in = LP_GO;
            end
         end
         LP_GO:   state_in = LP_WAIT;
         LP_WAIT: begin
            if (log_done) begin
               d_in     = signed'(D_W'({log_res, 1'b0})) - signed'(D_W'({LFS, 1'b0}));
               dbpk_in  = 1'b1;
               state_in = DB_MUL;
            end
         end
         DELIVER: begin
            if (!ov_ff || rsp_ch.ready) begin
               ov_in         = 1'b1;
               o_lvl_in      = lvl_ff;
               o_rdb_in      = rdb_ff;
               o_rsil_in     = rsil_ff;
               o_pdb_in      = pdb_ff;
               o_psil_in     = psil_ff;
               o_emp_in      = empty_ff;
               o_pk_in       = empty_ff ? '0 : pk_ext[OUT_W-1:0];
               o_min_in      = empty_ff ? '0 : min_ext[OUT_W-1:0];
               o_max_in      = empty_ff ? '0 : max_ext[OUT_W-1:0];
               o_tot_in      = tally;
               acc_ctl.clear = 1'b1;
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      last_ff    <= last_in;
      lvl_ff     <= lvl_in;
      rdb_ff     <= rdb_in;
      rsil_ff    <= rsil_in;
      pdb_ff     <= pdb_in;
      psil_ff    <= psil_in;
      empty_ff   <= empty_in;
      lsum_ff    <= lsum_in;
      d_ff       <= d_in;
      p_ff       <= p_in;
      dbpk_ff    <= dbpk_in;
      o_lvl_ff   <= o_lvl_in;
      o_rdb_ff   <= o_rdb_in;
      o_rsil_ff  <= o_rsil_in;
      o_pdb_ff   <= o_pdb_in;
      o_psil_ff  <= o_psil_in;
      o_pk_ff    <= o_pk_in;
      o_min_ff   <= o_min_in;
      o_max_ff   <= o_max_in;
      o_tot_ff   <= o_tot_in;
      o_emp_ff   <= o_emp_in;
   end

   // result channel
   assign rsp_ch.valid        = ov_ff;
   assign rsp_ch.rms_level    = o_lvl_ff;
   assign rsp_ch.rms_db       = o_rdb_ff;
   assign rsp_ch.rms_silent   = o_rsil_ff;
   assign rsp_ch.peak_db      = o_pdb_ff;
   assign rsp_ch.peak_silent  = o_psil_ff;
   assign rsp_ch.peak_value   = o_pk_ff;
   assign rsp_ch.min_value    = o_min_ff;
   assign rsp_ch.max_value    = o_max_ff;
   assign rsp_ch.sample_total = o_tot_ff;
   assign rsp_ch.window_empty = o_emp_ff;

endmodule

/* hdl/arpm_checker.sv */
// Port-level checks of the level meter, bound to the top level.
// Depends on the channel interfaces in arpm_if.sv.
module arpm_checker (
   input logic        clock,
   input logic        reset,
   arpm_req_if.sink   req_ch,
   arpm_rsp_if.source rsp_ch
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its RMS level, both dB fields and its sample total
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         $stable(rsp_ch.rms_level) && $stable(rsp_ch.rms_db) &&
         $stable(rsp_ch.peak_db) && $stable(rsp_ch.sample_total))
      else $error("result payload changed while stalled");

   // a sample or a close keeps the input busy for the next cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && (req_ch.sample_present || req_ch.last)
         |=> !req_ch.ready)
      else $error("request taken while busy");

   // an empty window reports silence and no samples
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.window_empty |->
         rsp_ch.rms_silent && rsp_ch.peak_silent && rsp_ch.sample_total == '0 &&
         rsp_ch.rms_level == '0)
      else $error("empty window with nonzero fields");

   // silent levels carry a zero dB field
   a_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.rms_silent || rsp_ch.peak_silent) |->
         (!rsp_ch.rms_silent || rsp_ch.rms_db == '0) &&
         (!rsp_ch.peak_silent || rsp_ch.peak_db == '0))
      else $error("silent level with nonzero dB");

endmodule

bind audio_rms_peak_level_meter arpm_checker u_arpm_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
